@@ src/qrs_pkg.sv @@
// Shared widths, result codes and pipeline transaction types for the quadratic root solver.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package qrs_pkg;

    // Number format of coefficients and roots
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int TOL_WIDTH  = 16;

    // Derived widths
    localparam int PROD_W    = 2 * DATA_WIDTH;       // one coefficient product
    localparam int DISC_W    = 2 * DATA_WIDTH + 2;   // b*b - 4*a*c, signed
    localparam int SQ_W      = DATA_WIDTH + 1;       // integer root of the discriminant
    localparam int SQ_REM_W  = SQ_W + 2;             // square root remainder
    localparam int NUM_W     = DATA_WIDTH + 3;       // signed numerator
    localparam int NUM_MAG_W = DATA_WIDTH + 2;       // numerator magnitude
    localparam int QUO_W     = NUM_MAG_W + FRAC_BITS; // dividend and quotient
    localparam int DEN_W     = DATA_WIDTH + 1;       // divisor magnitude, 2*|a| or |b|
    localparam int CNT_W     = 2;

    // Reset value of the zero tolerance register
    localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(1);

    // Root count codes
    localparam logic [CNT_W-1:0] CNT_NONE = 2'd0;
    localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
    localparam logic [CNT_W-1:0] CNT_TWO  = 2'd2;
    localparam logic [CNT_W-1:0] CNT_INF  = 2'd3;

    // Square root chain: working data and side information
    typedef struct packed {
        logic [DISC_W-1:0]   rad;
        logic [SQ_REM_W-1:0] rem;
        logic [SQ_W-1:0]     root;
    } t_sq_data;

    typedef struct packed {
        logic [CNT_W-1:0]      count;
        logic                  lin;
        logic [DATA_WIDTH-1:0] a;
        logic [DATA_WIDTH-1:0] b;
        logic [DATA_WIDTH-1:0] c;
    } t_sq_side;

    // Divider chain: two lanes sharing one divisor
    typedef struct packed {
        logic [QUO_W-1:0] num1;
        logic [QUO_W-1:0] num2;
        logic [QUO_W-1:0] quo1;
        logic [QUO_W-1:0] quo2;
        logic [DEN_W-1:0] rem1;
        logic [DEN_W-1:0] rem2;
        logic [DEN_W-1:0] den;
    } t_dv_data;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             neg1;
        logic             neg2;
        logic             zero_div1;
        logic             zero_div2;
    } t_dv_side;

endpackage

@@ src/qrs_sqrt_cell.sv @@
// One cell of the integer square root chain: resolves one root bit per transaction.
// Depends on qrs_pkg.
`timescale 1ns / 1ps

module qrs_sqrt_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  qrs_pkg::t_sq_data i_data,
    input  qrs_pkg::t_sq_side i_side,
    output logic              o_valid,
    output qrs_pkg::t_sq_data o_data,
    output qrs_pkg::t_sq_side o_side
);

    logic [qrs_pkg::SQ_REM_W+1:0] w_acc;
    logic [qrs_pkg::SQ_REM_W+1:0] w_trial;
    logic [qrs_pkg::SQ_REM_W+1:0] w_diff;
    logic                         w_ge;
    qrs_pkg::t_sq_data            n_data;
    logic                         r_valid;
    qrs_pkg::t_sq_data            r_data;
    qrs_pkg::t_sq_side            r_side;

    // Bring down the next radicand bit pair and try the next root bit
    always_comb begin
        w_acc   = {i_data.rem, i_data.rad[qrs_pkg::DISC_W-1 -: 2]};
        w_trial = {2'b00, i_data.root, 2'b01};
        w_ge    = (w_acc >= w_trial);
        w_diff  = w_acc - w_trial;
        n_data.rad  = i_data.rad << 2;
        n_data.rem  = w_ge ? w_diff[qrs_pkg::SQ_REM_W-1:0] : w_acc[qrs_pkg::SQ_REM_W-1:0];
        n_data.root = {i_data.root[qrs_pkg::SQ_W-2:0], w_ge};
    end

    // Advance the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Advance the payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_side  = r_side;

endmodule

@@ src/qrs_div_cell.sv @@
// One cell of the restoring divider chain: one quotient bit for each of two lanes.
// Depends on qrs_pkg.
`timescale 1ns / 1ps

module qrs_div_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  qrs_pkg::t_dv_data i_data,
    input  qrs_pkg::t_dv_side i_side,
    output logic              o_valid,
    output qrs_pkg::t_dv_data o_data,
    output qrs_pkg::t_dv_side o_side
);

    logic [qrs_pkg::DEN_W:0] w_dext;
    logic [qrs_pkg::DEN_W:0] w_part1;
    logic [qrs_pkg::DEN_W:0] w_part2;
    logic [qrs_pkg::DEN_W:0] w_diff1;
    logic [qrs_pkg::DEN_W:0] w_diff2;
    logic                    w_ge1;
    logic                    w_ge2;
    qrs_pkg::t_dv_data       n_data;
    logic                    r_valid;
    qrs_pkg::t_dv_data       r_data;
    qrs_pkg::t_dv_side       r_side;

    // Shift in the next dividend bit and subtract the divisor where it fits
    always_comb begin
        w_dext  = {1'b0, i_data.den};
        w_part1 = {i_data.rem1, i_data.num1[qrs_pkg::QUO_W-1]};
        w_part2 = {i_data.rem2, i_data.num2[qrs_pkg::QUO_W-1]};
        w_ge1   = (w_part1 >= w_dext);
        w_ge2   = (w_part2 >= w_dext);
        w_diff1 = w_part1 - w_dext;
        w_diff2 = w_part2 - w_dext;
        n_data.num1 = i_data.num1 << 1;
        n_data.num2 = i_data.num2 << 1;
        n_data.quo1 = {i_data.quo1[qrs_pkg::QUO_W-2:0], w_ge1};
        n_data.quo2 = {i_data.quo2[qrs_pkg::QUO_W-2:0], w_ge2};
        n_data.rem1 = w_ge1 ? w_diff1[qrs_pkg::DEN_W-1:0] : w_part1[qrs_pkg::DEN_W-1:0];
        n_data.rem2 = w_ge2 ? w_diff2[qrs_pkg::DEN_W-1:0] : w_part2[qrs_pkg::DEN_W-1:0];
        n_data.den  = i_data.den;
    end

    // Advance the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Advance the payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_side  = r_side;

endmodule

@@ src/quadratic_root_solver.sv @@
// Top level of the quadratic root solver: front end, square root and divider chains, output.
// Depends on qrs_pkg, qrs_sqrt_cell and qrs_div_cell.
`timescale 1ns / 1ps

// Solves a*x^2 + b*x + c = 0 for signed Q16.16 coefficients.
// Input channel: i_in_valid / o_in_ready with a, b and c; a transaction is taken
// when both are high. Output channel: o_out_valid / i_out_ready with the root
// count, two Q16.16 roots and a saturation flag.
// Configuration: i_cfg_valid / o_cfg_ready with the 16-bit zero tolerance
// (reset value 1); the port is always ready. Write it only while the block is idle.
// The pipeline has two front stages (products, discriminant), 33 square
// root cells at one root bit each, a numerator stage, 50 divider cells at one
// quotient bit each, and the output register.
// Throughput is one transaction per cycle while the output is not stalled; the cell chains advance together.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// o_in_ready drops; it rises again as soon as the result is taken.
// Synchronous active-low reset clears all valid flags and sets the tolerance to 1;
// no clearing pass is needed.
module quadratic_root_solver (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic signed [qrs_pkg::DATA_WIDTH-1:0] i_coef_quad,
    input  logic signed [qrs_pkg::DATA_WIDTH-1:0] i_coef_lin,
    input  logic signed [qrs_pkg::DATA_WIDTH-1:0] i_coef_const,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [qrs_pkg::CNT_W-1:0]        o_root_count,
    output logic signed [qrs_pkg::DATA_WIDTH-1:0] o_root_first,
    output logic signed [qrs_pkg::DATA_WIDTH-1:0] o_root_second,
    output logic                             o_saturated,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [qrs_pkg::TOL_WIDTH-1:0]    i_cfg_zero_tolerance
);

    localparam int DW = qrs_pkg::DATA_WIDTH;

    // Clamp a quotient magnitude to the signed output range; returns {sat, root}
    function automatic logic [DW:0] f_clamp(input logic [qrs_pkg::QUO_W-1:0] quo,
                                            input logic neg, input logic zdiv);
        logic [qrs_pkg::QUO_W-1:0] lim_neg;
        logic [qrs_pkg::QUO_W-1:0] lim_pos;
        logic [DW-1:0]             res;
        logic                      sat;
        lim_neg         = '0;
        lim_neg[DW-1]   = 1'b1;
        lim_pos         = lim_neg - 1'b1;
        sat             = 1'b0;
        if (zdiv) begin
            res = '0;
        end else if (neg) begin
            if (quo > lim_neg) begin
                sat = 1'b1;
                res = {1'b1, {(DW-1){1'b0}}};
            end else begin
                res = ~quo[DW-1:0] + 1'b1;
            end
        end else begin
            if (quo > lim_pos) begin
                sat = 1'b1;
                res = {1'b0, {(DW-1){1'b1}}};
            end else begin
                res = quo[DW-1:0];
            end
        end
        return {sat, res};
    endfunction

    logic w_en;
    logic [qrs_pkg::TOL_WIDTH-1:0] r_tol;

    // Hold the whole pipeline only while a finished result waits
    assign w_en        = !o_out_valid || i_out_ready;
    assign o_in_ready  = w_en;
    assign o_cfg_ready = 1'b1;

    // Zero tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= qrs_pkg::TOL_RESET;
        end else if (i_cfg_valid) begin
            r_tol <= i_cfg_zero_tolerance;
        end
    end

    // ---------------- Stage 1: products and linear tests ----------------
    logic [DW-1:0]                       w_mag_a;
    logic [DW-1:0]                       w_mag_b;
    logic [DW-1:0]                       w_mag_c;
    logic [DW-1:0]                       w_tol_ext;
    logic signed [qrs_pkg::PROD_W-1:0]   w_bb;
    logic signed [qrs_pkg::PROD_W-1:0]   w_ac;
    logic [qrs_pkg::CNT_W-1:0]           w_lcount;
    logic                                r1_valid;
    logic signed [qrs_pkg::PROD_W-1:0]   r1_bb;
    logic signed [qrs_pkg::PROD_W-1:0]   r1_ac;
    logic [DW-1:0]                       r1_a;
    logic [DW-1:0]                       r1_b;
    logic [DW-1:0]                       r1_c;
    logic                                r1_lin;
    logic [qrs_pkg::CNT_W-1:0]           r1_lcount;

    always_comb begin
        w_mag_a   = i_coef_quad[DW-1]  ? (~i_coef_quad + 1'b1)  : i_coef_quad;
        w_mag_b   = i_coef_lin[DW-1]   ? (~i_coef_lin + 1'b1)   : i_coef_lin;
        w_mag_c   = i_coef_const[DW-1] ? (~i_coef_const + 1'b1) : i_coef_const;
        w_tol_ext = DW'(r_tol);
        w_bb      = i_coef_lin * i_coef_lin;
        w_ac      = i_coef_quad * i_coef_const;
        if (w_mag_b >= w_tol_ext) begin
            w_lcount = qrs_pkg::CNT_ONE;
        end else if (w_mag_c >= w_tol_ext) begin
            w_lcount = qrs_pkg::CNT_NONE;
        end else begin
            w_lcount = qrs_pkg::CNT_INF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_bb     <= w_bb;
            r1_ac     <= w_ac;
            r1_a      <= i_coef_quad;
            r1_b      <= i_coef_lin;
            r1_c      <= i_coef_const;
            r1_lin    <= (w_mag_a <= w_tol_ext);
            r1_lcount <= w_lcount;
        end
    end

    // ---------------- Stage 2: discriminant and root count ----------------
    logic signed [qrs_pkg::DISC_W-1:0] w_disc;
    logic signed [qrs_pkg::DISC_W-1:0] w_thr;
    logic signed [qrs_pkg::DISC_W-1:0] w_nthr;
    logic [qrs_pkg::CNT_W-1:0]         w_count;
    logic                              r2_valid;
    qrs_pkg::t_sq_data                 r2_data;
    qrs_pkg::t_sq_side                 r2_side;

    always_comb begin
        w_disc = $signed({{2{r1_bb[qrs_pkg::PROD_W-1]}}, r1_bb}) - $signed({r1_ac, 2'b00});
        w_thr  = $signed({{(qrs_pkg::DISC_W-qrs_pkg::TOL_WIDTH-qrs_pkg::FRAC_BITS){1'b0}},
                          r_tol, {qrs_pkg::FRAC_BITS{1'b0}}});
        w_nthr = -w_thr;
        if (r1_lin) begin
            w_count = r1_lcount;
        end else if (w_disc >= w_thr) begin
            w_count = qrs_pkg::CNT_TWO;
        end else if (w_disc >= w_nthr) begin
            w_count = qrs_pkg::CNT_ONE;
        end else begin
            w_count = qrs_pkg::CNT_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_data.rad  <= (!r1_lin && (w_count == qrs_pkg::CNT_TWO)) ? w_disc : '0;
            r2_data.rem  <= '0;
            r2_data.root <= '0;
            r2_side.count <= w_count;
            r2_side.lin   <= r1_lin;
            r2_side.a     <= r1_a;
            r2_side.b     <= r1_b;
            r2_side.c     <= r1_c;
        end
    end

    // ---------------- Square root chain ----------------
    logic              w_sq_valid [0:qrs_pkg::SQ_W];
    qrs_pkg::t_sq_data w_sq_data  [0:qrs_pkg::SQ_W];
    qrs_pkg::t_sq_side w_sq_side  [0:qrs_pkg::SQ_W];

    assign w_sq_valid[0] = r2_valid;
    assign w_sq_data[0]  = r2_data;
    assign w_sq_side[0]  = r2_side;

    for (genvar g = 0; g < qrs_pkg::SQ_W; g++) begin : g_sqrt
        qrs_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sq_valid[g]),
            .i_data  (w_sq_data[g]),
            .i_side  (w_sq_side[g]),
            .o_valid (w_sq_valid[g+1]),
            .o_data  (w_sq_data[g+1]),
            .o_side  (w_sq_side[g+1])
        );
    end

    // ---------------- Stage 3: numerators and divisor ----------------
    qrs_pkg::t_sq_side                  w_sd;
    logic signed [qrs_pkg::NUM_W-1:0]   w_s;
    logic signed [qrs_pkg::NUM_W-1:0]   w_b;
    logic signed [qrs_pkg::NUM_W-1:0]   w_c;
    logic signed [qrs_pkg::NUM_W-1:0]   w_n1;
    logic signed [qrs_pkg::NUM_W-1:0]   w_n2;
    logic signed [qrs_pkg::NUM_W-1:0]   w_neg_n1;
    logic signed [qrs_pkg::NUM_W-1:0]   w_neg_n2;
    logic signed [qrs_pkg::DEN_W-1:0]   w_den;
    logic signed [qrs_pkg::DEN_W-1:0]   w_neg_den;
    logic [qrs_pkg::NUM_MAG_W-1:0]      w_m1;
    logic [qrs_pkg::NUM_MAG_W-1:0]      w_m2;
    logic [qrs_pkg::DEN_W-1:0]          w_dm;
    logic                               r3_valid;
    qrs_pkg::t_dv_data                  r3_data;
    qrs_pkg::t_dv_side                  r3_side;

    always_comb begin
        w_sd = w_sq_side[qrs_pkg::SQ_W];
        w_s  = $signed({{(qrs_pkg::NUM_W-qrs_pkg::SQ_W){1'b0}}, w_sq_data[qrs_pkg::SQ_W].root});
        w_b  = $signed({{(qrs_pkg::NUM_W-DW){w_sd.b[DW-1]}}, w_sd.b});
        w_c  = $signed({{(qrs_pkg::NUM_W-DW){w_sd.c[DW-1]}}, w_sd.c});
        if (w_sd.lin) begin
            w_den = $signed({w_sd.b[DW-1], w_sd.b});
            w_n1  = -w_c;
            w_n2  = -w_c;
        end else if (w_sd.count == qrs_pkg::CNT_TWO) begin
            w_den = $signed({w_sd.a, 1'b0});
            w_n1  = w_s - w_b;
            w_n2  = -w_s - w_b;
        end else begin
            w_den = $signed({w_sd.a, 1'b0});
            w_n1  = -w_b;
            w_n2  = -w_b;
        end
        w_neg_n1  = -w_n1;
        w_neg_n2  = -w_n2;
        w_neg_den = -w_den;
        w_m1 = w_n1[qrs_pkg::NUM_W-1] ? w_neg_n1[qrs_pkg::NUM_MAG_W-1:0]
                                      : w_n1[qrs_pkg::NUM_MAG_W-1:0];
        w_m2 = w_n2[qrs_pkg::NUM_W-1] ? w_neg_n2[qrs_pkg::NUM_MAG_W-1:0]
                                      : w_n2[qrs_pkg::NUM_MAG_W-1:0];
        w_dm = w_den[qrs_pkg::DEN_W-1] ? w_neg_den : w_den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_en) begin
            r3_valid <= w_sq_valid[qrs_pkg::SQ_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_data.num1 <= {w_m1, {qrs_pkg::FRAC_BITS{1'b0}}};
            r3_data.num2 <= {w_m2, {qrs_pkg::FRAC_BITS{1'b0}}};
            r3_data.quo1 <= '0;
            r3_data.quo2 <= '0;
            r3_data.rem1 <= '0;
            r3_data.rem2 <= '0;
            r3_data.den  <= w_dm;
            r3_side.count     <= w_sd.count;
            r3_side.neg1      <= w_n1[qrs_pkg::NUM_W-1] ^ w_den[qrs_pkg::DEN_W-1];
            r3_side.neg2      <= w_n2[qrs_pkg::NUM_W-1] ^ w_den[qrs_pkg::DEN_W-1];
            r3_side.zero_div1 <= (w_dm == '0) && (w_n1 == '0);
            r3_side.zero_div2 <= (w_dm == '0) && (w_n2 == '0);
        end
    end

    // ---------------- Divider chain ----------------
    logic              w_dv_valid [0:qrs_pkg::QUO_W];
    qrs_pkg::t_dv_data w_dv_data  [0:qrs_pkg::QUO_W];
    qrs_pkg::t_dv_side w_dv_side  [0:qrs_pkg::QUO_W];

    assign w_dv_valid[0] = r3_valid;
    assign w_dv_data[0]  = r3_data;
    assign w_dv_side[0]  = r3_side;

    for (genvar g = 0; g < qrs_pkg::QUO_W; g++) begin : g_div
        qrs_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_dv_valid[g]),
            .i_data  (w_dv_data[g]),
            .i_side  (w_dv_side[g]),
            .o_valid (w_dv_valid[g+1]),
            .o_data  (w_dv_data[g+1]),
            .o_side  (w_dv_side[g+1])
        );
    end

    // ---------------- Output register ----------------
    qrs_pkg::t_dv_side         w_fs;
    logic [DW:0]               w_r1;
    logic [DW:0]               w_r2;
    logic                      w_has_root;
    logic                      r_out_valid;
    logic [qrs_pkg::CNT_W-1:0] r_count;
    logic [DW-1:0]             r_first;
    logic [DW-1:0]             r_second;
    logic                      r_sat;

    always_comb begin
        w_fs = w_dv_side[qrs_pkg::QUO_W];
        w_r1 = f_clamp(w_dv_data[qrs_pkg::QUO_W].quo1, w_fs.neg1, w_fs.zero_div1);
        w_r2 = f_clamp(w_dv_data[qrs_pkg::QUO_W].quo2, w_fs.neg2, w_fs.zero_div2);
        w_has_root = (w_fs.count == qrs_pkg::CNT_ONE) || (w_fs.count == qrs_pkg::CNT_TWO);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_dv_valid[qrs_pkg::QUO_W];
        end
    end

    // Drop the roots when there are none or infinitely many
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_count  <= w_fs.count;
            r_first  <= w_has_root ? w_r1[DW-1:0] : '0;
            r_second <= w_has_root ? w_r2[DW-1:0] : '0;
            r_sat    <= w_has_root && (w_r1[DW] || w_r2[DW]);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_root_count  = r_count;
    assign o_root_first  = r_first;
    assign o_root_second = r_second;
    assign o_saturated   = r_sat;

    // ---------------- Assertions ----------------
    a_no_root_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_root_count == qrs_pkg::CNT_NONE || o_root_count == qrs_pkg::CNT_INF)
        |-> (o_root_first == '0) && (o_root_second == '0) && !o_saturated)
        else $error("roots or flag set without a finite root");

    a_one_root_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_root_count == qrs_pkg::CNT_ONE) |-> (o_root_first == o_root_second))
        else $error("single root differs between outputs");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input held off without an output stall");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_root_first)
        && $stable(o_root_count))
        else $error("stalled result changed");

endmodule
